// ===== design/dts_shs_pkg.sv =====
// Package for the DTS sync header scanner: payload structs, sync constants,
// the rate table and the reciprocal constant for the frame size division.
// No dependencies.
package dts_shs_pkg;

    localparam int WINDOW_W         = 16;
    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd7056;
    localparam int OFFSET_BITS_DEF  = 16;
    localparam int HIST_LEN         = 10;
    localparam int HDR_LAST         = HIST_LEN - 1;   // byte index of header end
    localparam int SYNC_LEAD        = 4;              // sync start + 13 vs window

    // Sync word: ff 1f 00 e8, then f? nibble, then 07
    localparam logic [7:0] SYNC_B0   = 8'hff;
    localparam logic [7:0] SYNC_B1   = 8'h1f;
    localparam logic [7:0] SYNC_B2   = 8'h00;
    localparam logic [7:0] SYNC_B3   = 8'he8;
    localparam logic [3:0] SYNC_B4HI = 4'hf;
    localparam logic [7:0] SYNC_B5   = 8'h07;

    // floor(x / 7) == (x * DIV7_MUL) >> DIV7_SHIFT for x < 2^17
    localparam logic [17:0] DIV7_MUL   = 18'd149797;
    localparam int          DIV7_SHIFT = 20;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_RATE = 2'd1;
    localparam logic [1:0] ST_NO_SYNC  = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       restart;
    } t_in_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] sync_offset;
        logic [12:0] frame_samples;
        logic [14:0] frame_bytes;
        logic [17:0] rate_hz;
        logic [3:0]  rate_code;
    } t_out_res;

    // Scan result handed from the scanner to the decoder
    typedef struct packed {
        logic        hdr;        // 1: header found, 0: no sync
        logic [15:0] offset;
        logic [6:0]  nblks;
        logic [13:0] fsize_raw;
        logic [3:0]  code;
    } t_evt;

    function automatic logic [17:0] rate_lookup(input logic [3:0] code);
        logic [17:0] r;
        unique case (code)
            4'd1:    r = 18'd8000;
            4'd2:    r = 18'd16000;
            4'd3:    r = 18'd32000;
            4'd6:    r = 18'd11025;
            4'd7:    r = 18'd22050;
            4'd8:    r = 18'd44100;
            4'd11:   r = 18'd12000;
            4'd12:   r = 18'd24000;
            4'd13:   r = 18'd48000;
            4'd14:   r = 18'd96000;
            4'd15:   r = 18'd192000;
            default: r = 18'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== design/dts_shs_scan.sv =====
// Byte history, byte counter and sync search for the DTS header scanner.
// Registers one scan result per stream. Depends on dts_shs_pkg.
module dts_shs_scan
    import dts_shs_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [WINDOW_W-1:0] i_scan_window,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  t_in_req             i_in_req,
    output logic                o_evt_valid,
    input  logic                i_evt_ready,
    output t_evt                o_evt
);

    localparam int CW = ((OFFSET_BITS > WINDOW_W) ? OFFSET_BITS : WINDOW_W) + 1;
    localparam logic [OFFSET_BITS-1:0] COUNT_MAX = {OFFSET_BITS{1'b1}};

    logic [7:0]             r_hist [HIST_LEN];
    logic [7:0]             n_hist [HIST_LEN];
    logic [7:0]             eff_hist [HIST_LEN];
    logic [OFFSET_BITS-1:0] r_count, eff_count;
    logic                   r_done, eff_done;
    logic                   r_evt_valid;
    t_evt                   r_evt, n_evt;
    logic [CW-1:0]          pos_ext, win_ext;
    logic                   acc, sync_hit, hit, miss_end;

    assign o_in_ready  = !r_evt_valid || i_evt_ready;
    assign acc         = i_in_valid && o_in_ready;
    assign o_evt_valid = r_evt_valid;
    assign o_evt       = r_evt;

    // restart clears the search state before this byte is taken as byte 0
    always_comb begin
        for (int i = 0; i < HIST_LEN; i++) begin
            eff_hist[i] = i_in_req.restart ? 8'h00 : r_hist[i];
        end
        eff_count = i_in_req.restart ? '0 : r_count;
        eff_done  = i_in_req.restart ? 1'b0 : r_done;
        for (int i = 0; i < HIST_LEN - 1; i++) begin
            n_hist[i] = eff_hist[i+1];
        end
        n_hist[HIST_LEN-1] = i_in_req.data_byte;
    end

    assign sync_hit = n_hist[0] == SYNC_B0 && n_hist[1] == SYNC_B1 &&
                      n_hist[2] == SYNC_B2 && n_hist[3] == SYNC_B3 &&
                      n_hist[4][7:4] == SYNC_B4HI && n_hist[5] == SYNC_B5;

    assign pos_ext  = CW'(eff_count);
    assign win_ext  = CW'(i_scan_window);
    assign hit      = pos_ext >= CW'(HDR_LAST) &&
                      (pos_ext + CW'(SYNC_LEAD)) < win_ext && sync_hit;
    assign miss_end = (pos_ext + CW'(1)) >= win_ext;

    always_comb begin
        n_evt.hdr       = hit;
        n_evt.offset    = 16'(pos_ext - CW'(HDR_LAST));
        n_evt.nblks     = {n_hist[4][2:0], n_hist[7][5:2]};
        n_evt.fsize_raw = {n_hist[7][1:0], n_hist[6], n_hist[9][5:2]};
        n_evt.code      = n_hist[8][3:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < HIST_LEN; i++) begin
                r_hist[i] <= 8'h00;
            end
            r_count     <= '0;
            r_done      <= 1'b0;
            r_evt_valid <= 1'b0;
        end else begin
            if (acc && !eff_done) begin
                r_hist  <= n_hist;
                r_count <= (eff_count < COUNT_MAX) ? eff_count + OFFSET_BITS'(1)
                                                   : eff_count;
                r_done  <= hit || miss_end;
            end else if (acc) begin
                r_done <= eff_done;
            end
            if (acc && !eff_done && (hit || miss_end)) begin
                r_evt_valid <= 1'b1;
            end else if (i_evt_ready) begin
                r_evt_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && !eff_done && (hit || miss_end)) begin
            r_evt <= n_evt;
        end
    end

    // a pending result always belongs to a finished search
    a_evt_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_evt_valid |-> r_done)
        else $error("scan result pending without search done");

    // bytes after the result leave the counter alone
    a_done_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && r_done && !i_in_req.restart) |=> $stable(r_count))
        else $error("byte counter moved after search done");

endmodule

// ===== design/dts_shs_dec.sv =====
// Header field decoder and result register for the DTS header scanner.
// Frame size divide by 7 is a reciprocal multiply. Depends on dts_shs_pkg.
module dts_shs_dec
    import dts_shs_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_evt_valid,
    output logic     o_evt_ready,
    input  t_evt     i_evt,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_out_res o_out_res
);

    logic        r_out_valid;
    t_out_res    r_out, n_out;
    logic [14:0] fsize;
    logic [16:0] fsize_x4;
    logic [34:0] prod;
    logic [14:0] quot;
    logic [7:0]  nblks_p1;
    logic [17:0] rate;
    logic        load;

    assign o_evt_ready = !r_out_valid || i_out_ready;
    assign load        = i_evt_valid && o_evt_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out;

    assign fsize    = {1'b0, i_evt.fsize_raw} + 15'd1;
    assign fsize_x4 = {fsize, 2'b00};
    assign prod     = 35'(fsize_x4) * 35'(DIV7_MUL);
    assign quot     = prod[DIV7_SHIFT +: 15];
    assign nblks_p1 = {1'b0, i_evt.nblks} + 8'd1;
    assign rate     = rate_lookup(i_evt.code);

    always_comb begin
        n_out = '0;
        if (i_evt.hdr) begin
            n_out.status        = (rate == 18'd0) ? ST_BAD_RATE : ST_OK;
            n_out.sync_offset   = i_evt.offset;
            n_out.frame_samples = {nblks_p1, 5'b00000};
            n_out.frame_bytes   = 15'({quot, 1'b0});
            n_out.rate_hz       = rate;
            n_out.rate_code     = i_evt.code;
        end else begin
            n_out.status = ST_NO_SYNC;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= n_out;
        end
    end

    a_nosync_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == ST_NO_SYNC) |->
            (r_out.frame_bytes == 15'd0 && r_out.rate_hz == 18'd0 &&
             r_out.frame_samples == 13'd0))
        else $error("no-sync result carries header fields");

    a_ok_rate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == ST_OK) |-> r_out.rate_hz != 18'd0)
        else $error("header ok with zero sample rate");

endmodule

// ===== design/dts_sync_header_scanner.sv =====
// Top level of the DTS 14-bit little-endian sync scanner and header parser.
// Instantiates dts_shs_scan and dts_shs_dec; depends on dts_shs_pkg.
//
// Feed the stream one byte per request, with restart set on the first byte
// of each stream. The block looks for the first DTS sync (ff 1f 00 e8, f?,
// 07) within the first scan_window bytes and returns at most one result per
// stream: a decoded header (status ok, or bad rate when the rate code maps
// to zero) once the tenth byte from the sync has arrived, or a no-sync
// report when the last byte of the window arrives without a usable sync.
// Bytes after the result are taken and dropped until the next restart.
// One byte is accepted every cycle; the result passes through the scan
// register, then the result register, and the input stalls only while
// a scan result waits behind an untaken result. Write scan_window only
// while the block is idle.
module dts_sync_header_scanner
    import dts_shs_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration: scan window in bytes
    input  logic                i_cfg_we,
    input  logic [WINDOW_W-1:0] i_cfg_wdata,
    // byte requests
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  t_in_req             i_in_req,
    // results
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output t_out_res            o_out_res
);

    logic [WINDOW_W-1:0] r_scan_window;
    logic                evt_valid;
    logic                evt_ready;
    t_evt                evt;

    // scan window register, reset to 40 ms of 44.1 kHz 16-bit stereo
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_window <= WINDOW_RESET;
        end else if (i_cfg_we) begin
            r_scan_window <= i_cfg_wdata;
        end
    end

    // sync search: history shift register, counter, window checks
    dts_shs_scan #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_scan_window (r_scan_window),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in_req      (i_in_req),
        .o_evt_valid   (evt_valid),
        .i_evt_ready   (evt_ready),
        .o_evt         (evt)
    );

    // field decode: block count, frame bytes, rate table, status
    dts_shs_dec u_dec (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_evt_valid (evt_valid),
        .o_evt_ready (evt_ready),
        .i_evt       (evt),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_res   (o_out_res)
    );

endmodule

// ===== dv/dts_sync_header_scanner_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for dts_sync_header_scanner: byte streams in, at most one header or
// no-sync report per stream out, checked against an in-bench scan model.
// Depends on dts_shs_pkg and the scanner RTL.
module dts_sync_header_scanner_test;
    import dts_shs_pkg::*;

    localparam int          LIMIT_CYCLES  = 400000;
    localparam int          SETTLE_CYCLES = 8;    // result lags its byte through the scan and result registers
    localparam int          LONG_HOLD     = 400;  // receiver stall for the fill-up test
    localparam logic [15:0] WIN_MIN       = 16'd16;
    localparam logic [15:0] WIN_MAX       = 16'hffff;

    // Hertz per 4-bit rate code; zero marks a code with no defined rate
    localparam int unsigned RATE_HZ_LUT [16] = '{
        0, 8000, 16000, 32000, 0, 0, 11025, 22050,
        44100, 0, 0, 12000, 24000, 48000, 96000, 192000
    };

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [15:0] i_cfg_wdata;
    logic       i_in_valid;
    logic       o_in_ready;
    t_in_req    i_in_req;
    logic       o_out_valid;
    logic       i_out_ready;
    t_out_res   o_out_res;

    dts_sync_header_scanner u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_res   (o_out_res)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Scan model state: last ten bytes, position of the next byte in the
    // stream, whether this stream already produced its one report, and
    // the scan window as last written.
    // ------------------------------------------------------------------
    logic [7:0]  seen_bytes [HIST_LEN];
    logic [15:0] stream_pos;
    logic        stream_closed;
    logic [15:0] window_bytes;

    t_out_res    pending_reports [$];   // predicted reports, oldest first
    int unsigned live_items;            // requests that were not dropped after a report
    int unsigned err_count;
    int unsigned cycle_count;

    int unsigned tx_idle_pct;
    int unsigned rx_idle_pct;
    int unsigned rx_hold_cycles;

    // Runs one accepted byte through the scan model. Returns 1 with the
    // report filled in when this byte closes the stream.
    function automatic bit scan_stream_byte(input t_in_req req, output t_out_res rpt);
        int unsigned pos;
        int unsigned nblks;
        int unsigned fsize;
        int unsigned rate;
        int          i;
        rpt = '0;
        if (req.restart) begin
            for (i = 0; i < HIST_LEN; i++) seen_bytes[i] = 8'h00;
            stream_pos    = '0;
            stream_closed = 1'b0;
        end
        // after its report a stream is silent until the next restart
        if (stream_closed) return 1'b0;
        live_items++;

        for (i = 0; i < HIST_LEN - 1; i++) seen_bytes[i] = seen_bytes[i + 1];
        seen_bytes[HIST_LEN - 1] = req.data_byte;
        pos = stream_pos;
        if (stream_pos != '1) stream_pos++;   // counter saturates

        // Sync sits in the oldest history byte; it only counts while
        // offset + 13 stays inside the window (pos = offset + 9).
        if (pos >= HDR_LAST && pos + SYNC_LEAD < window_bytes &&
            seen_bytes[0] == SYNC_B0 && seen_bytes[1] == SYNC_B1 &&
            seen_bytes[2] == SYNC_B2 && seen_bytes[3] == SYNC_B3 &&
            seen_bytes[4][7:4] == SYNC_B4HI && seen_bytes[5] == SYNC_B5) begin
            nblks = {seen_bytes[4][2:0], seen_bytes[7][5:2]};
            fsize = {seen_bytes[7][1:0], seen_bytes[6], seen_bytes[9][5:2]} + 1;
            rate  = RATE_HZ_LUT[seen_bytes[8][3:0]];
            rpt.status        = (rate == 0) ? ST_BAD_RATE : ST_OK;
            rpt.sync_offset   = 16'(pos - HDR_LAST);
            rpt.frame_samples = 13'((nblks + 1) * 32);
            rpt.frame_bytes   = 15'((fsize * 8 / 14) * 2);
            rpt.rate_hz       = 18'(rate);
            rpt.rate_code     = seen_bytes[8][3:0];
            stream_closed = 1'b1;
            return 1'b1;
        end
        // last byte of the window without a usable sync
        if (pos + 1 >= window_bytes) begin
            rpt.status    = ST_NO_SYNC;
            stream_closed = 1'b1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void check_field(input string fname, input logic [31:0] want_v,
                                        input logic [31:0] got_v);
        if (want_v !== got_v) begin
            err_count++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, fname, want_v, got_v);
        end
    endfunction

    // ------------------------------------------------------------------
    // Monitor: at each rising edge, check an accepted report against the
    // oldest prediction, predict from an accepted request, then track
    // window writes (a write lands after the byte of the same edge).
    // Inputs only move at the falling edge, so all values read here are
    // settled.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_out_res rpt;
        t_out_res want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (pending_reports.size() == 0) begin
                    err_count++;
                    $display("%0t: unexpected report, expected none, actual %h", $time,
                             o_out_res);
                end else begin
                    want = pending_reports.pop_front();
                    check_field("status", want.status, o_out_res.status);
                    check_field("sync_offset", want.sync_offset, o_out_res.sync_offset);
                    check_field("frame_samples", want.frame_samples,
                                o_out_res.frame_samples);
                    check_field("frame_bytes", want.frame_bytes, o_out_res.frame_bytes);
                    check_field("rate_hz", want.rate_hz, o_out_res.rate_hz);
                    check_field("rate_code", want.rate_code, o_out_res.rate_code);
                end
            end
            if (i_in_valid && o_in_ready) begin
                if (scan_stream_byte(i_in_req, rpt)) pending_reports.push_back(rpt);
            end
            if (i_cfg_we) window_bytes = i_cfg_wdata;
        end
    end

    // Receiver: a long hold-off when requested, otherwise random stalls
    always @(negedge i_clk) begin
        if (rx_hold_cycles != 0) begin
            rx_hold_cycles--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Request side. All tasks start and end at a falling edge. Valid is
    // left high between back-to-back requests and only dropped for a gap.
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic rs);
        if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req   <= '{data_byte: b, restart: rs};
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // First byte of every stream carries restart
    task automatic send_stream_bytes(input logic [7:0] strm [$]);
        int k;
        for (k = 0; k < strm.size(); k++) send_byte(strm[k], k == 0);
    endtask

    // Sender pause: wait out every pending report plus the pipeline
    task automatic wait_results_drained();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (pending_reports.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_scan_window(input logic [15:0] w);
        i_cfg_wdata <= w;
        i_cfg_we    <= 1'b1;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Sync plus the four header bytes that carry the decoded fields
    task automatic push_header(ref logic [7:0] strm [$], input logic [3:0] b4_lo,
                               input logic [7:0] b6, b7, b8, b9);
        strm.push_back(SYNC_B0);
        strm.push_back(SYNC_B1);
        strm.push_back(SYNC_B2);
        strm.push_back(SYNC_B3);
        strm.push_back({SYNC_B4HI, b4_lo});
        strm.push_back(SYNC_B5);
        strm.push_back(b6);
        strm.push_back(b7);
        strm.push_back(b8);
        strm.push_back(b9);
    endtask

    // Filler biased toward sync bytes so partial and repeated syncs show up
    function automatic logic [7:0] filler_byte();
        logic [7:0] sync_like [6];
        sync_like = '{SYNC_B0, SYNC_B1, SYNC_B2, SYNC_B3, {SYNC_B4HI, 4'h9}, SYNC_B5};
        if ($urandom_range(0, 3) == 0) return sync_like[$urandom_range(0, 5)];
        return 8'($urandom);
    endfunction

    // One random stream: mostly a header after random lead-in, the rest
    // broken syncs, headers cut short by the next restart, and noise.
    task automatic send_stream(input logic [15:0] win);
        logic [7:0]  strm [$];
        int unsigned kind;
        int unsigned lead;
        int unsigned n;
        int unsigned pick;
        kind = $urandom_range(0, 9);
        lead = $urandom_range(0, (win < 40) ? win : 40);
        repeat (lead) strm.push_back(filler_byte());
        if (kind <= 8) begin
            push_header(strm, 4'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                        8'($urandom));
        end
        if (kind == 7) begin
            // corrupt one sync byte; in the nibble byte only the fixed half
            pick = $urandom_range(0, 5);
            strm[lead + pick] ^= 8'(1 << ((pick == 4) ? $urandom_range(4, 7)
                                                       : $urandom_range(0, 7)));
        end else if (kind == 8) begin
            // header cut short before its tenth byte
            n = $urandom_range(1, 9);
            while (strm.size() > lead + n) void'(strm.pop_back());
        end else if (kind == 9) begin
            n = (win <= 200) ? $urandom_range(1, win + 4) : $urandom_range(1, 40);
            repeat (n) strm.push_back(filler_byte());
        end
        repeat ($urandom_range(0, 3)) strm.push_back(filler_byte());
        send_stream_bytes(strm);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset window (7056): header at offset 0 with every field at its
    // maximum and the top rate code, then a byte that must be dropped.
    task automatic test_reset_window();
        logic [7:0] strm [$];
        tx_idle_pct = 28;
        rx_idle_pct = 64;
        push_header(strm, 4'hf, 8'hff, 8'hff, 8'hff, 8'hff);
        strm.push_back(SYNC_B0);
        send_stream_bytes(strm);
        wait_results_drained();
    endtask

    // Smallest window: minimum fields with an undefined rate code at the
    // last offset that still fits, then a sync one byte too late.
    task automatic test_small_window();
        logic [7:0] strm [$];
        set_scan_window(WIN_MIN);
        repeat (2) strm.push_back(8'($urandom));
        push_header(strm, 4'h0, 8'h00, 8'h00, 8'hf0, 8'h00);
        send_stream_bytes(strm);
        strm.delete();
        repeat (3) strm.push_back(8'($urandom));
        push_header(strm, 4'h3, 8'h5a, 8'h81, 8'h0d, 8'h3c);
        repeat (3) strm.push_back(8'($urandom));
        send_stream_bytes(strm);
        wait_results_drained();
    endtask

    // Random streams in segments; each segment drains, then picks a new
    // window. The first two segments use the range's extremes.
    task automatic run_random_phase(input int unsigned tx_pct, rx_pct,
                                    input logic [15:0] win_lo, win_hi,
                                    input int unsigned n_live);
        int unsigned goal;
        int unsigned seg;
        int unsigned near_hi;
        logic [15:0] w;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        goal    = live_items + n_live;
        near_hi = (win_hi < win_lo + 64) ? win_hi : win_lo + 64;
        seg     = 0;
        while (live_items < goal) begin
            wait_results_drained();
            case (seg)
                0: w = win_lo;
                1: w = win_hi;
                default: w = $urandom_range(0, 1) ? 16'($urandom_range(win_lo, near_hi))
                                                  : 16'($urandom_range(win_lo, win_hi));
            endcase
            set_scan_window(w);
            repeat (6) send_stream(w);
            seg++;
        end
    endtask

    // Receiver holds off for a long stretch while short streams keep
    // coming, so reports back up and the input must stall.
    task automatic test_backpressure();
        logic [7:0] strm [$];
        int s;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        wait_results_drained();
        set_scan_window(WIN_MIN);
        rx_hold_cycles = LONG_HOLD;
        for (s = 0; s < 8; s++) begin
            strm.delete();
            repeat (WIN_MIN) strm.push_back(filler_byte());
            send_stream_bytes(strm);
        end
        wait_results_drained();
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_wdata    = '0;
        i_in_valid     = 1'b0;
        i_in_req       = '0;
        i_out_ready    = 1'b0;
        tx_idle_pct    = 0;
        rx_idle_pct    = 0;
        rx_hold_cycles = 0;
        live_items     = 0;
        err_count      = 0;
        cycle_count    = 0;
        stream_pos     = '0;
        stream_closed  = 1'b0;
        window_bytes   = WINDOW_RESET;
        for (int i = 0; i < HIST_LEN; i++) seen_bytes[i] = 8'h00;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_window();
        test_small_window();
        run_random_phase(28, 64, WIN_MIN, 16'd48, 600);
        run_random_phase(64, 28, WIN_MIN, WIN_MAX, 600);
        run_random_phase(0, 0, WIN_MIN, 16'd160, 550);
        test_backpressure();
        wait_results_drained();

        if (err_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== sim.f =====
design/dts_shs_pkg.sv
design/dts_shs_scan.sv
design/dts_shs_dec.sv
design/dts_sync_header_scanner.sv
dv/dts_sync_header_scanner_test.sv
